// ===== rtl/tlb_fifo_page_translator_top_defines.svh =====
// assertion macros for the tlb page translator
`ifndef TLB_FIFO_PAGE_TRANSLATOR_TOP_DEFINES_SVH
`define TLB_FIFO_PAGE_TRANSLATOR_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// clocked check, masked while reset is high
`define TFPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// clocked check that also holds during reset
`define TFPT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TFPT_ASSERT(lbl, prop, msg)
`define TFPT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/tlb_fpt_pkg.sv =====
package tlb_fpt_pkg;

  // address split
  localparam int VA_W        = 16;
  localparam int OFFSET_BITS = 8;
  localparam int PAGE_COUNT  = 256;
  localparam int FRAME_COUNT = 256;
  localparam int PAGE_W      = $clog2(PAGE_COUNT);
  localparam int FRAME_W     = $clog2(FRAME_COUNT);

  // statistics counters
  localparam int TOTAL_W = 32;

  // default tlb size
  localparam int TLB_DEPTH_DEF = 16;

  // controller states
  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic lookup;
    logic commit;
  } ctrl_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic out_busy;
  } dp_status_t;

endpackage

// ===== rtl/tlb_fpt_ctrl.sv =====
module tlb_fpt_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  tlb_fpt_pkg::dp_status_t status,
  output tlb_fpt_pkg::ctrl_cmd_t  cmd
);
  import tlb_fpt_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (!status.out_busy) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready   = 1'b0;
    cmd.lookup = 1'b0;
    cmd.commit = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.lookup = in_valid;
      end
      ST_UPDATE: begin
        cmd.commit = !status.out_busy;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/tlb_fpt_dp.sv =====
`include "tlb_fifo_page_translator_top_defines.svh"

module tlb_fpt_dp #(
  parameter int TLB_DEPTH = tlb_fpt_pkg::TLB_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  tlb_fpt_pkg::ctrl_cmd_t              cmd,
  output tlb_fpt_pkg::dp_status_t             status,
  input  logic [tlb_fpt_pkg::VA_W-1:0]        virt_addr,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [tlb_fpt_pkg::VA_W-1:0]        phys_addr,
  output logic [tlb_fpt_pkg::FRAME_W-1:0]     frame_out,
  output logic                                tlb_hit,
  output logic                                page_fault,
  output logic [tlb_fpt_pkg::TOTAL_W-1:0]     hit_total,
  output logic [tlb_fpt_pkg::TOTAL_W-1:0]     fault_total
);
  import tlb_fpt_pkg::*;

  localparam int IDX_W = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1;
  localparam int CNT_W = $clog2(TLB_DEPTH + 1);

  // tlb entries and fifo pointers
  logic [PAGE_W-1:0]  tlb_page  [TLB_DEPTH];
  logic [FRAME_W-1:0] tlb_frame [TLB_DEPTH];
  logic [CNT_W-1:0]   tlb_count;
  logic [IDX_W-1:0]   tlb_oldest;

  // page table: valid bits in flops, frames in memory
  logic [PAGE_COUNT-1:0] pt_valid;
  logic [FRAME_W-1:0]    pt_frame [PAGE_COUNT];
  logic [FRAME_W-1:0]    pt_rdata;

  logic [FRAME_W-1:0] next_free;
  logic [TOTAL_W-1:0] hits_acc;
  logic [TOTAL_W-1:0] faults_acc;

  // lookup stage registers
  logic [PAGE_W-1:0]      page_q;
  logic [OFFSET_BITS-1:0] offset_q;
  logic                   hit_q;
  logic [FRAME_W-1:0]     hit_frame_q;
  logic                   pt_valid_q;

  logic [PAGE_W-1:0]  page_in;
  logic [TLB_DEPTH-1:0] match;
  logic [FRAME_W-1:0] match_frame;
  logic               fault;
  logic               full;
  logic [FRAME_W-1:0] frame_sel;

  assign page_in = virt_addr[OFFSET_BITS +: PAGE_W];
  assign full    = (tlb_count == CNT_W'(TLB_DEPTH));

  // parallel tag compare; pages are unique so the matches are or-ed
  always_comb begin
    match_frame = '0;
    for (int i = 0; i < TLB_DEPTH; i++) begin
      match[i] = (CNT_W'(i) < tlb_count) && (tlb_page[i] == page_in);
      if (match[i]) match_frame = match_frame | tlb_frame[i];
    end
  end

  // lookup capture
  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      page_q      <= page_in;
      offset_q    <= virt_addr[OFFSET_BITS-1:0];
      hit_q       <= |match;
      hit_frame_q <= match_frame;
      pt_valid_q  <= pt_valid[page_in];
    end
  end

  // frame choice for the commit cycle
  assign fault     = !hit_q && !pt_valid_q;
  assign frame_sel = hit_q ? hit_frame_q : (pt_valid_q ? pt_rdata : next_free);

  // page table frame memory
  always_ff @(posedge clk) begin
    if (cmd.commit && fault) pt_frame[page_q] <= next_free;
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) pt_rdata <= pt_frame[page_in];
  end

  // tlb entry writes
  always_ff @(posedge clk) begin
    if (cmd.commit && !hit_q) begin
      if (full) begin
        tlb_page[tlb_oldest]  <= page_q;
        tlb_frame[tlb_oldest] <= frame_sel;
      end else begin
        tlb_page[tlb_count[IDX_W-1:0]]  <= page_q;
        tlb_frame[tlb_count[IDX_W-1:0]] <= frame_sel;
      end
    end
  end

  // control state: fifo pointers, valid bits, allocator, totals
  always_ff @(posedge clk) begin
    if (rst) begin
      tlb_count  <= '0;
      tlb_oldest <= '0;
      pt_valid   <= '0;
      next_free  <= '0;
      hits_acc   <= '0;
      faults_acc <= '0;
    end else if (cmd.commit) begin
      if (hit_q) begin
        if (hits_acc != '1) hits_acc <= hits_acc + TOTAL_W'(1);
      end else begin
        if (full) begin
          tlb_oldest <= (tlb_oldest == IDX_W'(TLB_DEPTH - 1)) ? '0 : tlb_oldest + IDX_W'(1);
        end else begin
          tlb_count <= tlb_count + CNT_W'(1);
        end
        if (fault) begin
          pt_valid[page_q] <= 1'b1;
          next_free <= (next_free == FRAME_W'(FRAME_COUNT - 1)) ? '0
                                                                 : next_free + FRAME_W'(1);
          if (faults_acc != '1) faults_acc <= faults_acc + TOTAL_W'(1);
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      phys_addr  <= {frame_sel, offset_q};
      frame_out  <= frame_sel;
      tlb_hit    <= hit_q;
      page_fault <= fault;
    end
  end

  // totals only move on commit, which needs a free result slot
  assign hit_total   = hits_acc;
  assign fault_total = faults_acc;

  assign status.out_busy = out_valid && !out_ready;

  `TFPT_ASSERT(a_count_bound, tlb_count <= CNT_W'(TLB_DEPTH), "tlb count beyond depth")
  `TFPT_ASSERT(a_oldest_only_full, (tlb_oldest != '0) |-> full, "fifo pointer moved before full")
  `TFPT_ASSERT(a_hit_not_fault, out_valid |-> !(tlb_hit && page_fault), "hit and fault together")
  `TFPT_ASSERT(a_fault_counted, (cmd.commit && fault && faults_acc != '1) |=> (faults_acc == $past(faults_acc) + TOTAL_W'(1)), "fault not counted")

endmodule

// ===== rtl/tlb_fifo_page_translator_top.sv =====
// tlb page translator: virtual to physical address with fifo tlb and demand paging
//
// input channel: in_valid / in_ready with virt_addr (page in bits 15..8, offset 7..0)
// output channel: out_valid / out_ready with phys_addr, frame_out, tlb_hit,
// page_fault and the saturating hit_total and fault_total counts
//
// a request is accepted in the idle cycle, where the tlb tags are compared and the
// page table read is issued; the update state then commits the tlb, table and counters
// and loads the result register once the result slot is free
// a new request is taken only after the last one has committed, since each needs
// the tlb and page table read-then-update loop before the next lookup
//
// reset empties the tlb, marks every page table entry invalid, restarts frame
// allocation at zero and clears both totals
// when the receiver stalls, one result waits in the output register while the
// next request is still taken and looked up; its commit waits for the slot
module tlb_fifo_page_translator_top #(
  parameter int TLB_DEPTH = tlb_fpt_pkg::TLB_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [tlb_fpt_pkg::VA_W-1:0]    virt_addr,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [tlb_fpt_pkg::VA_W-1:0]    phys_addr,
  output logic [tlb_fpt_pkg::FRAME_W-1:0] frame_out,
  output logic                            tlb_hit,
  output logic                            page_fault,
  output logic [tlb_fpt_pkg::TOTAL_W-1:0] hit_total,
  output logic [tlb_fpt_pkg::TOTAL_W-1:0] fault_total
);
  import tlb_fpt_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // sequencer
  tlb_fpt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // tlb, page table and result datapath
  tlb_fpt_dp #(
    .TLB_DEPTH (TLB_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .virt_addr   (virt_addr),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .phys_addr   (phys_addr),
    .frame_out   (frame_out),
    .tlb_hit     (tlb_hit),
    .page_fault  (page_fault),
    .hit_total   (hit_total),
    .fault_total (fault_total)
  );

endmodule
